>>> design/ird_pkg.sv
`default_nettype none

package ird_pkg;

    localparam int unsigned LEVEL_W = 12;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 12;

    // filtered = (7*f + 3*raw) / 10; the weighted sum stays below 2^16
    localparam int unsigned FSUM_W = 16;
    localparam logic [FSUM_W-1:0] FILT_OLD_WEIGHT = 16'd7;
    localparam logic [FSUM_W-1:0] FILT_NEW_WEIGHT = 16'd3;
    // x / 10 == (x * 0xCCCD) >> 19, exact for x below 81920
    localparam logic [FSUM_W-1:0] DIV10_RECIP = 16'hCCCD;
    localparam int unsigned DIV10_SHIFT = 19;

    // baseline = (63*b + f) / 64
    localparam int unsigned BSUM_W = 18;
    localparam logic [BSUM_W-1:0] BASE_OLD_WEIGHT = 18'd63;
    localparam int unsigned BASE_SHIFT = 6;

    localparam logic [LEVEL_W-1:0] ENTER_DELTA_RST = 12'd300;
    localparam logic [LEVEL_W-1:0] EXIT_DELTA_RST = 12'd150;
    localparam logic [COUNT_W-1:0] CONFIRM_SAMPLES_RST = 8'd3;
    localparam logic [COUNT_W-1:0] CLEAR_SAMPLES_RST = 8'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_DELTA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_DELTA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_SAMPLES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_SAMPLES = 2'd3;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [LEVEL_W-1:0] sample;
    } ird_req_t;

    typedef struct packed {
        logic               detected;
        logic               event_taken;
        logic [LEVEL_W-1:0] filtered_level;
        logic [LEVEL_W-1:0] baseline_level;
    } ird_res_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] enter_delta;
        logic [LEVEL_W-1:0] exit_delta;
        logic [COUNT_W-1:0] confirm_samples;
        logic [COUNT_W-1:0] clear_samples;
    } ird_cfg_t;

endpackage

`default_nettype wire

>>> design/ir_obstacle_detector_top.sv
// A request waits in the request register until the result register can take its result.
// Throughput: one request per cycle if m_ready keeps up; ird_core's loop is combinational.
// While a result waits on m_ready, one more request can sit in the request register;
// s_ready then stays low until the waiting result is taken.
// Reset: aresetn, synchronous, active low; clears all but payload; loads register defaults.
`default_nettype none

module ir_obstacle_detector_top
    import ird_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // request channel
    input  wire logic                  s_valid,
    output      logic                  s_ready,
    input  wire ird_req_t              s_req,
    // result channel
    output      logic                  m_valid,
    input  wire logic                  m_ready,
    output ird_res_t                   m_res
);

    ird_cfg_t cfg;
    ird_res_t core_res;

    // request register
    logic     req_valid_reg;
    ird_req_t req_reg;
    // result register
    logic     res_valid_reg;
    ird_res_t res_reg;

    logic advance;   // result register can take a new value
    logic step;      // request register content is processed this cycle

    assign advance = !res_valid_reg || m_ready;
    assign step    = req_valid_reg && advance;
    assign s_ready = !req_valid_reg || advance;

    ird_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // filter, thresholds, baseline tracking and debounce counters
    ird_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (req_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                req_valid_reg <= 1'b1;
            end else if (step) begin
                req_valid_reg <= 1'b0;
            end
            if (step) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_req;
        end
        if (step) begin
            res_reg <= core_res;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_res   = res_reg;

    // every processed request produces a result the next cycle
    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> res_valid_reg)
        else $error("processed request produced no result");

    // a held result stays put until taken
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && !m_ready) |=> (res_valid_reg && $stable(res_reg)))
        else $error("stalled result changed");

    // the request register never drops an unprocessed request
    a_request_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (req_valid_reg && !step) |=> (req_valid_reg && $stable(req_reg)))
        else $error("pending request lost");

endmodule

`default_nettype wire

>>> design/ird_cfg.sv
`default_nettype none

module ird_cfg
    import ird_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output ird_cfg_t                   cfg
);

    ird_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enter_delta     <= ENTER_DELTA_RST;
            cfg_reg.exit_delta      <= EXIT_DELTA_RST;
            cfg_reg.confirm_samples <= CONFIRM_SAMPLES_RST;
            cfg_reg.clear_samples   <= CLEAR_SAMPLES_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_ENTER_DELTA:     cfg_reg.enter_delta     <= cfg_wdata[LEVEL_W-1:0];
                CFG_EXIT_DELTA:      cfg_reg.exit_delta      <= cfg_wdata[LEVEL_W-1:0];
                CFG_CONFIRM_SAMPLES: cfg_reg.confirm_samples <= cfg_wdata[COUNT_W-1:0];
                CFG_CLEAR_SAMPLES:   cfg_reg.clear_samples   <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/ird_core.sv
`default_nettype none

module ird_core
    import ird_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire ird_req_t req,
    input  wire ird_cfg_t cfg,
    output ird_res_t      res
);

    logic               seeded_reg, seeded_next;
    logic [LEVEL_W-1:0] filter_reg, filter_next;
    logic [LEVEL_W-1:0] baseline_reg, baseline_next;
    logic [COUNT_W-1:0] confirm_reg, confirm_next;
    logic [COUNT_W-1:0] release_reg, release_next;
    logic               detect_reg, detect_next;
    logic               event_reg, event_next;
    logic               taken;

    logic [FSUM_W-1:0]    fsum;
    logic [2*FSUM_W-1:0]  fprod;
    logic [LEVEL_W-1:0]   filt;
    logic [LEVEL_W-1:0]   base_cur;
    logic [LEVEL_W:0]     enter_th;
    logic [LEVEL_W:0]     exit_th;
    logic [BSUM_W-1:0]    bsum;
    logic                 below_exit;
    logic                 above_enter;

    always_comb begin
        fsum = FILT_OLD_WEIGHT * FSUM_W'(filter_reg) + FILT_NEW_WEIGHT * FSUM_W'(req.sample);
        fprod = (2*FSUM_W)'(fsum) * (2*FSUM_W)'(DIV10_RECIP);
        // first sample seeds filter and baseline directly
        filt     = seeded_reg ? fprod[DIV10_SHIFT +: LEVEL_W] : req.sample;
        base_cur = seeded_reg ? baseline_reg : req.sample;
        enter_th = {1'b0, base_cur} + {1'b0, cfg.enter_delta};
        exit_th  = {1'b0, base_cur} + {1'b0, cfg.exit_delta};
        below_exit  = {1'b0, filt} < exit_th;
        above_enter = {1'b0, filt} > enter_th;
        bsum = BASE_OLD_WEIGHT * BSUM_W'(base_cur) + BSUM_W'(filt);

        seeded_next   = seeded_reg;
        filter_next   = filter_reg;
        baseline_next = baseline_reg;
        confirm_next  = confirm_reg;
        release_next  = release_reg;
        detect_next   = detect_reg;
        event_next    = event_reg;
        taken         = 1'b0;

        if (req.req_type == REQ_CONSUME) begin
            taken      = event_reg;
            event_next = 1'b0;
        end else begin
            seeded_next   = 1'b1;
            filter_next   = filt;
            baseline_next = base_cur;
            if (!detect_reg) begin
                if (below_exit) begin
                    baseline_next = bsum[BASE_SHIFT +: LEVEL_W];
                end
                if (above_enter) begin
                    if (confirm_reg < cfg.confirm_samples) begin
                        confirm_next = confirm_reg + COUNT_W'(1);
                    end
                end else begin
                    confirm_next = '0;
                end
                if (confirm_next >= cfg.confirm_samples) begin
                    detect_next  = 1'b1;
                    event_next   = 1'b1;
                    release_next = '0;
                end
            end else begin
                if (below_exit) begin
                    if (release_reg < cfg.clear_samples) begin
                        release_next = release_reg + COUNT_W'(1);
                    end
                end else begin
                    release_next = '0;
                end
                if (release_next >= cfg.clear_samples) begin
                    detect_next  = 1'b0;
                    confirm_next = '0;
                end
            end
        end

        res.detected       = detect_next;
        res.event_taken    = taken;
        res.filtered_level = filter_next;
        res.baseline_level = baseline_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seeded_reg   <= 1'b0;
            filter_reg   <= '0;
            baseline_reg <= '0;
            confirm_reg  <= '0;
            release_reg  <= '0;
            detect_reg   <= 1'b0;
            event_reg    <= 1'b0;
        end else if (step) begin
            seeded_reg   <= seeded_next;
            filter_reg   <= filter_next;
            baseline_reg <= baseline_next;
            confirm_reg  <= confirm_next;
            release_reg  <= release_next;
            detect_reg   <= detect_next;
            event_reg    <= event_next;
        end
    end

    // a new detection always latches an event
    a_detect_sets_event: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(detect_reg) |-> event_reg)
        else $error("detection rose without a latched event");

    // nothing can be detected before the first sample
    a_no_detect_unseeded: assert property (@(posedge aclk) disable iff (!aresetn)
        !seeded_reg |-> (!detect_reg && !event_reg && filter_reg == '0 && baseline_reg == '0))
        else $error("state moved before seeding");

    // baseline stays frozen while a detection is held
    a_baseline_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && detect_reg && seeded_reg) |=> $stable(baseline_reg))
        else $error("baseline moved during detection");

    // a consume request only touches the event flag
    a_consume_only_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && req.req_type == REQ_CONSUME) |=> (!event_reg && $stable(filter_reg)
            && $stable(detect_reg) && $stable(confirm_reg) && $stable(release_reg)))
        else $error("consume request changed detector state");

endmodule

`default_nettype wire

>>> tb/sv/ird_tb_pkg.sv
`timescale 1ns / 100ps

package ird_tb_pkg;

    import ird_pkg::*;

    // Tracks detector state, predicts one result per request and checks
    // results in order.
    class ird_scoreboard;

        ird_cfg_t           cfg;
        bit                 seeded;
        logic [LEVEL_W-1:0] filt;
        logic [LEVEL_W-1:0] base;
        logic [COUNT_W-1:0] confirm_cnt;
        logic [COUNT_W-1:0] release_cnt;
        bit                 detected;
        bit                 event_pending;

        ird_res_t    expected_q[$];
        int unsigned mismatches;
        int unsigned detections;
        int unsigned events_taken;

        function void power_on();
            cfg.enter_delta = ENTER_DELTA_RST;
            cfg.exit_delta = EXIT_DELTA_RST;
            cfg.confirm_samples = CONFIRM_SAMPLES_RST;
            cfg.clear_samples = CLEAR_SAMPLES_RST;
            seeded = 1'b0;
            filt = '0;
            base = '0;
            confirm_cnt = '0;
            release_cnt = '0;
            detected = 1'b0;
            event_pending = 1'b0;
            expected_q.delete();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_ENTER_DELTA: cfg.enter_delta = val;
                CFG_EXIT_DELTA: cfg.exit_delta = val;
                CFG_CONFIRM_SAMPLES: cfg.confirm_samples = val[COUNT_W-1:0];
                CFG_CLEAR_SAMPLES: cfg.clear_samples = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(ird_req_t r);
            ird_res_t    want;
            int unsigned fsum;
            int unsigned bsum;
            int unsigned enter_th;
            int unsigned exit_th;
            want.event_taken = 1'b0;
            if (r.req_type == REQ_SAMPLE) begin
                if (!seeded) begin
                    filt = r.sample;
                    base = r.sample;
                    seeded = 1'b1;
                end else begin
                    fsum = 7 * int'(filt) + 3 * int'(r.sample);
                    filt = LEVEL_W'(fsum / 10);
                end
                // thresholds use the baseline before this sample moves it
                enter_th = int'(base) + int'(cfg.enter_delta);
                exit_th = int'(base) + int'(cfg.exit_delta);
                if (!detected) begin
                    if (filt < exit_th) begin
                        bsum = 63 * int'(base) + int'(filt);
                        base = LEVEL_W'(bsum / 64);
                    end
                    if (filt > enter_th) begin
                        if (confirm_cnt < cfg.confirm_samples)
                            confirm_cnt = confirm_cnt + 1'b1;
                    end else begin
                        confirm_cnt = '0;
                    end
                    if (confirm_cnt >= cfg.confirm_samples) begin
                        detected = 1'b1;
                        event_pending = 1'b1;
                        release_cnt = '0;
                        detections++;
                    end
                end else begin
                    if (filt < exit_th) begin
                        if (release_cnt < cfg.clear_samples)
                            release_cnt = release_cnt + 1'b1;
                    end else begin
                        release_cnt = '0;
                    end
                    if (release_cnt >= cfg.clear_samples) begin
                        detected = 1'b0;
                        confirm_cnt = '0;
                    end
                end
            end else begin
                want.event_taken = event_pending;
                if (event_pending)
                    events_taken++;
                event_pending = 1'b0;
            end
            want.detected = detected;
            want.filtered_level = filt;
            want.baseline_level = base;
            expected_q.push_back(want);
        endfunction

        function void report(string what, ird_res_t want, ird_res_t got);
            mismatches++;
            if (mismatches <= 10)
                $display({"%0t: %s: expected det=%0d evt=%0d filt=%0d base=%0d,",
                          " got det=%0d evt=%0d filt=%0d base=%0d"},
                         $time, what, want.detected, want.event_taken, want.filtered_level,
                         want.baseline_level, got.detected, got.event_taken,
                         got.filtered_level, got.baseline_level);
        endfunction

        function void check_result(ird_res_t got);
            ird_res_t want;
            bit       bad;
            if (expected_q.size() == 0) begin
                want = '0;
                report("result with no request outstanding", want, got);
                return;
            end
            want = expected_q.pop_front();
            bad = (got.detected !== want.detected)
                || (got.event_taken !== want.event_taken)
                || (got.filtered_level !== want.filtered_level)
                || (got.baseline_level !== want.baseline_level);
            if (bad)
                report("result mismatch", want, got);
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

    endclass

endpackage

>>> tb/sv/tb_ir_obstacle_detector_top.sv
`timescale 1ns / 100ps

module tb_ir_obstacle_detector_top;

    import ird_pkg::*;
    import ird_tb_pkg::*;

    // cycles without any handshake before the run is declared hung;
    // the longest legal quiet stretch is the forced receiver stall below
    localparam int unsigned STUCK_LIMIT = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 150;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    ird_req_t              s_req;
    logic                  m_valid;
    logic                  m_ready;
    ird_res_t              m_res;

    ird_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned hold_left;
    int unsigned hold_reqs;
    int unsigned hold_done;
    int unsigned stuck_cycles;
    int unsigned n_sent;
    int unsigned n_requests;
    int unsigned n_results;
    int unsigned n_cfg_writes;

    ir_obstacle_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Handshake monitor. Runs at the edge and sees pre-edge values, so the
    // order against the driver processes does not matter. Requests are noted
    // before results are checked in case a result ever shares the edge.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_request(s_req);
            n_requests++;
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_res);
            n_results++;
        end
    end

    // Result sink: random back-pressure, plus a long forced stall whenever
    // the stimulus asks for one. The stall is counted here, not in the driver.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_done != hold_reqs) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_OFF_CYCLES - 1;
            hold_done <= hold_done + 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog: any handshake on either side resets the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
                         stuck_cycles, sb.pending());
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Offer one request; random idle cycles first, then hold valid until taken.
    task automatic send_req(input ird_req_t r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_req <= r;
        do @(posedge aclk); while (!(s_valid && s_ready));
        n_sent++;
    endtask

    task automatic send_sample(input logic [LEVEL_W-1:0] v);
        ird_req_t r;
        r.req_type = REQ_SAMPLE;
        r.sample = v;
        send_req(r);
    endtask

    // The sample field rides along with random content; the block ignores it.
    task automatic send_consume();
        ird_req_t r;
        r.req_type = REQ_CONSUME;
        r.sample = LEVEL_W'($urandom_range(0, 4095));
        send_req(r);
    endtask

    // Sender pause: drop valid and wait out every outstanding result. Each
    // request yields exactly one result, so an empty queue means idle.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(negedge aclk); while (sb.pending() != 0);
        @(posedge aclk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_reg(idx, val);
        n_cfg_writes++;
    endtask

    // Write all four registers back to back. pad fills the unused upper bits
    // of the count registers, which the block must drop.
    task automatic load_thresholds(input logic [LEVEL_W-1:0] enter_d,
                                   input logic [LEVEL_W-1:0] exit_d,
                                   input logic [COUNT_W-1:0] confirm_n,
                                   input logic [COUNT_W-1:0] clear_n,
                                   input logic [CFG_DATA_W-COUNT_W-1:0] pad);
        put_reg(CFG_ENTER_DELTA, enter_d);
        put_reg(CFG_EXIT_DELTA, exit_d);
        put_reg(CFG_CONFIRM_SAMPLES, {pad, confirm_n});
        put_reg(CFG_CLEAR_SAMPLES, {pad, clear_n});
        cfg_we <= 1'b0;
    endtask

    function automatic logic [LEVEL_W-1:0] near_level(int unsigned lvl, int unsigned spread);
        int unsigned v;
        v = lvl + $urandom_range(0, spread);
        if (v > 4095)
            v = 4095;
        return LEVEL_W'(v);
    endfunction

    // Count limits: mostly short, with the zero and full-scale corners mixed in.
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return COUNT_W'($urandom_range(1, 6));
        endcase
    endfunction

    task automatic load_random_thresholds();
        logic [LEVEL_W-1:0] enter_d;
        logic [LEVEL_W-1:0] exit_d;
        enter_d = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                              : LEVEL_W'($urandom_range(40, 700));
        exit_d = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                             : LEVEL_W'($urandom_range(0, enter_d));
        load_thresholds(enter_d, exit_d, pick_count(), pick_count(),
                        (CFG_DATA_W-COUNT_W)'($urandom_range(0, 15)));
    endtask

    // A plausible obstacle pass: quiet floor, a bump above the enter
    // threshold, back to the floor, with event reads sprinkled in.
    task automatic obstacle_pass();
        int unsigned floor_lvl;
        int unsigned peak;
        floor_lvl = $urandom_range(0, 3000);
        peak = floor_lvl + sb.cfg.enter_delta + $urandom_range(1, 900);
        repeat ($urandom_range(2, 8)) send_sample(near_level(floor_lvl, 30));
        repeat ($urandom_range(1, 12)) send_sample(near_level(peak, 60));
        if ($urandom_range(0, 1) == 0)
            send_consume();
        repeat ($urandom_range(1, 12)) send_sample(near_level(floor_lvl, 30));
        if ($urandom_range(0, 2) == 0)
            send_consume();
    endtask

    task automatic run_segment(input int unsigned n);
        int unsigned stop_at;
        stop_at = n_sent + n;
        while (n_sent < stop_at) begin
            case ($urandom_range(0, 9))
                7, 8: repeat ($urandom_range(1, 6))
                          send_sample(LEVEL_W'($urandom_range(0, 4095)));
                9: repeat ($urandom_range(1, 2)) send_consume();
                default: obstacle_pass();
            endcase
        end
    endtask

    initial begin
        sb.power_on();
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_req <= '0;
        hold_reqs <= 0;
        recv_idle_pct <= 0;
        send_idle_pct = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part ----
        // Reset defaults: read before anything is seeded, seed at zero, drive
        // full scale until the confirm count trips, read the event twice.
        send_consume();
        send_sample('0);
        repeat (4) send_sample('1);
        send_consume();
        send_consume();
        repeat (3) send_sample('0);
        send_sample(12'hAAA);
        send_sample(12'h555);
        drain_results();

        // Clear count of zero: the first sample while detected releases.
        load_thresholds('0, '1, 8'd255, '0, '0);
        send_sample('0);
        drain_results();

        // Full-scale confirm limit: count climbs without detecting.
        load_thresholds('0, '0, '1, '1, '0);
        repeat (7) send_sample('1);
        drain_results();

        // Confirm limit lowered under the running count: the count is held,
        // detection fires on the next high sample; a clear count of one
        // releases at once; then the latched event is read.
        load_thresholds('0, '1, 8'd5, 8'd1, '0);
        send_sample('1);
        send_sample('0);
        send_consume();
        drain_results();

        // Confirm count of zero with the enter threshold out of reach:
        // detection happens anyway on the first clear sample.
        load_thresholds('1, '0, '0, '1, '0);
        send_sample(12'h123);
        send_consume();
        drain_results();

        // ---- random part ----
        // Three pressure modes: slow sender / slower sink, the reverse, and
        // full rate. Each mode gets several threshold settings.
        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 33;
                    recv_idle_pct <= 77;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct <= 33;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++) begin
                drain_results();
                load_random_thresholds();
                // full-rate mode opens with a long sink stall so the block
                // backs up and pushes back on s_ready
                if (mode == 2 && seg == 0)
                    hold_reqs <= hold_reqs + 1;
                run_segment(55);
            end
        end

        drain_results();
        repeat (8) @(posedge aclk);

        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        $display("Covered %0d requests and %0d results across %0d register writes",
                 n_requests, n_results, n_cfg_writes);
        $display("Predicted %0d detections; %0d latched events were read back",
                 sb.detections, sb.events_taken);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
